[hw/rtl/svnc_pkg.sv]
`default_nettype none
package svnc_pkg;

    localparam int VOICES_DEF     = 8;
    localparam int HELD_DEPTH_DEF = 8;

    localparam int OP_W       = 2;
    localparam int VIDX_W     = 3;
    localparam int KEY_W      = 7;
    localparam int VEL_W      = 7;
    localparam int STAT_W     = 2;
    localparam int ENV_W      = 2;
    localparam int MONO_W     = 2;
    localparam int GLIDE_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [OP_W-1:0] OP_NOTE_ON   = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF  = 2'd1;
    localparam logic [OP_W-1:0] OP_FORCE_REL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OFF = 2'd0;
    localparam logic [STAT_W-1:0] ST_ON  = 2'd1;
    localparam logic [STAT_W-1:0] ST_SUS = 2'd2;
    localparam logic [STAT_W-1:0] ST_REL = 2'd3;

    localparam logic [ENV_W-1:0] ENV_ATTACK  = 2'd0;
    localparam logic [ENV_W-1:0] ENV_RELEASE = 2'd2;

    localparam logic [MONO_W-1:0] MONO_POLY = 2'd0;
    localparam logic [MONO_W-1:0] MONO_ON   = 2'd1;
    localparam logic [MONO_W-1:0] MONO_ONCE = 2'd2;
    localparam logic [MONO_W-1:0] MONO_BOTH = 2'd3;

    localparam logic [GLIDE_W-1:0] GLIDE_OFF      = 3'd0;
    localparam logic [GLIDE_W-1:0] GLIDE_LEGATO   = 3'd1;
    localparam logic [GLIDE_W-1:0] GLIDE_INITIAL  = 3'd2;
    localparam logic [GLIDE_W-1:0] GLIDE_ALWAYS   = 3'd3;
    localparam logic [GLIDE_W-1:0] GLIDE_LEFTOVER = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MONO  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLIDE = 1'd1;

    localparam logic [VEL_W-1:0] REL_VEL_FORCED = 7'd64;

    typedef struct packed {
        logic [VIDX_W-1:0] voice_number;
        logic [STAT_W-1:0] voice_status;
        logic [KEY_W-1:0]  voice_key_now;
        logic [KEY_W-1:0]  target_key;
        logic [KEY_W-1:0]  glide_from_key;
        logic [VEL_W-1:0]  note_velocity;
        logic [VEL_W-1:0]  release_velocity;
        logic [ENV_W-1:0]  envelope_phase;
        logic              envelope_retrigger;
        logic              voice_started;
        logic [KEY_W-1:0]  top_held_key;
        logic              top_held_valid;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/svnc_ifs.sv]
`default_nettype none
interface svnc_note_if;
    import svnc_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [VIDX_W-1:0] voice_index;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
    logic              sustain_down;
    modport source (output valid, op, voice_index, key, velocity, sustain_down, input ready);
    modport sink   (input valid, op, voice_index, key, velocity, sustain_down, output ready);
endinterface

interface svnc_voice_if;
    import svnc_pkg::*;
    logic              valid;
    logic              ready;
    logic [VIDX_W-1:0] voice_number;
    logic [STAT_W-1:0] voice_status;
    logic [KEY_W-1:0]  voice_key_now;
    logic [KEY_W-1:0]  target_key;
    logic [KEY_W-1:0]  glide_from_key;
    logic [VEL_W-1:0]  note_velocity;
    logic [VEL_W-1:0]  release_velocity;
    logic [ENV_W-1:0]  envelope_phase;
    logic              envelope_retrigger;
    logic              voice_started;
    logic [KEY_W-1:0]  top_held_key;
    logic              top_held_valid;
    modport source (output valid, voice_number, voice_status, voice_key_now, target_key,
                    glide_from_key, note_velocity, release_velocity, envelope_phase,
                    envelope_retrigger, voice_started, top_held_key, top_held_valid,
                    input ready);
    modport sink   (input valid, voice_number, voice_status, voice_key_now, target_key,
                    glide_from_key, note_velocity, release_velocity, envelope_phase,
                    envelope_retrigger, voice_started, top_held_key, top_held_valid,
                    output ready);
endinterface

interface svnc_cfg_if;
    import svnc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/synth_voice_note_controller_unit.sv]
`default_nettype none
// Channel   Dir  Payload                                          Transfer
// i_cfg     in   index, data                                      valid & ready
// i_note    in   op, voice_index, key, velocity, sustain_down     valid & ready
// o_voice   out  voice fields, flags, top of held stack           valid & ready
//
// A note on or note off walks the held stack in the search state one entry a cycle with a
// single key comparator, then passes the shift state (a note off only on a hit) to update.
// Other events, and events for a voice out of range, go straight to the update state.
// i_note is ready only while the sequencer is idle. The result sits in an output register,
// so the next event is taken while it waits; a finished event waits while it is full.
// Synchronous active-low reset empties the stack and clears all voices.
module synth_voice_note_controller_unit #(
    parameter int VOICES     = svnc_pkg::VOICES_DEF,
    parameter int HELD_DEPTH = svnc_pkg::HELD_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    svnc_cfg_if.sink     i_cfg,
    svnc_note_if.sink    i_note,
    svnc_voice_if.source o_voice
);
    import svnc_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int HW = $clog2(HELD_DEPTH);
    localparam logic [HW-1:0] H_LAST = HW'(HELD_DEPTH - 1);
    localparam logic [HW-1:0] H_PEN  = HW'(HELD_DEPTH - 2);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_UPDATE} t_state;

    t_state             r_state;
    logic [HW-1:0]      r_idx;
    logic [MONO_W-1:0]  r_mono;
    logic [GLIDE_W-1:0] r_glide;
    logic [OP_W-1:0]    r_op;
    logic [VIDX_W-1:0]  r_vnum;
    logic [KEY_W-1:0]   r_key;
    logic [VEL_W-1:0]   r_vel;
    logic               r_sus;
    logic               r_prev_valid;
    logic [KEY_W-1:0]   r_prev_key;
    logic [KEY_W-1:0]   r_last_onset;
    logic               r_hv [HELD_DEPTH];
    logic [KEY_W-1:0]   r_hk [HELD_DEPTH];
    logic               n_hv [HELD_DEPTH];
    logic [KEY_W-1:0]   n_hk [HELD_DEPTH];
    logic [STAT_W-1:0]  r_vs [VOICES];
    logic [KEY_W-1:0]   r_vk [VOICES];
    logic [VEL_W-1:0]   r_vv [VOICES];
    logic [VEL_W-1:0]   r_vr [VOICES];
    logic [KEY_W-1:0]   r_vt [VOICES];
    logic [KEY_W-1:0]   r_vg [VOICES];
    logic [ENV_W-1:0]   r_ve [VOICES];
    t_result            r_res;
    t_result            n_res;
    logic               r_out_valid;

    logic               w_in_fire;
    logic               w_in_range;
    logic               w_hit;
    logic [VW-1:0]      w_vsel;
    logic [GLIDE_W-1:0] w_g;
    logic               w_mono;
    logic [STAT_W-1:0]  c_st;
    logic [STAT_W-1:0]  n_st;
    logic [KEY_W-1:0]   n_key;
    logic [KEY_W-1:0]   n_tgt;
    logic [KEY_W-1:0]   n_gs;
    logic [VEL_W-1:0]   n_vel;
    logic [VEL_W-1:0]   n_rel;
    logic [ENV_W-1:0]   n_env;
    logic               n_retrig;
    logic               n_started;
    logic               w_out_free;

    assign w_in_fire  = i_note.valid && i_note.ready;
    assign w_in_range = (int'(r_vnum) < VOICES);
    assign w_vsel     = VW'(r_vnum);
    assign w_hit      = r_hv[r_idx] && (r_hk[r_idx] == r_key);
    assign w_out_free = !r_out_valid || o_voice.ready;

    assign i_note.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    // stack cells: push moves entries 0..idx-1 down one, remove closes the gap at idx
    always_comb begin
        for (int i = 0; i < HELD_DEPTH; i++) begin
            n_hv[i] = r_hv[i];
            n_hk[i] = r_hk[i];
        end
        if (r_op == OP_NOTE_ON) begin
            n_hv[0] = 1'b1;
            n_hk[0] = r_key;
            for (int i = 1; i < HELD_DEPTH; i++) begin
                if (HW'(i) <= r_idx) begin
                    n_hv[i] = r_hv[i-1];
                    n_hk[i] = r_hk[i-1];
                end
            end
        end else begin
            for (int i = 0; i < HELD_DEPTH - 1; i++) begin
                if (HW'(i) >= r_idx) begin
                    n_hv[i] = r_hv[i+1];
                    n_hk[i] = r_hk[i+1];
                end
            end
            n_hv[HELD_DEPTH-1] = 1'b0;
            n_hk[HELD_DEPTH-1] = '0;
        end
    end

    always_comb begin
        w_g       = (r_glide > GLIDE_LEFTOVER) ? GLIDE_OFF : r_glide;
        w_mono    = (r_mono != MONO_POLY);
        c_st      = r_vs[w_vsel];
        n_st      = c_st;
        n_key     = r_vk[w_vsel];
        n_tgt     = r_vt[w_vsel];
        n_gs      = r_vg[w_vsel];
        n_vel     = r_vv[w_vsel];
        n_rel     = r_vr[w_vsel];
        n_env     = r_ve[w_vsel];
        n_retrig  = 1'b0;
        n_started = 1'b0;
        if (w_in_range) begin
            case (r_op)
                OP_NOTE_ON: begin
                    n_tgt = r_key;
                    if (!w_mono || !(c_st inside {ST_ON, ST_SUS})) begin
                        case (w_g)
                            GLIDE_OFF:     n_gs = r_key;
                            GLIDE_LEGATO:  n_gs = r_prev_valid ? r_prev_key : r_key;
                            GLIDE_INITIAL: n_gs = r_prev_valid ? r_key : r_last_onset;
                            GLIDE_ALWAYS:  n_gs = r_prev_valid ? r_prev_key : r_last_onset;
                            default:       n_gs = r_vg[w_vsel];
                        endcase
                        n_env    = ENV_ATTACK;
                        n_retrig = 1'b1;
                    end else begin
                        if (w_g inside {GLIDE_INITIAL, GLIDE_OFF}) begin
                            n_gs = r_key;
                        end
                        if ((r_mono inside {MONO_ON, MONO_BOTH}) &&
                            (!r_prev_valid || (r_prev_key != r_key))) begin
                            n_env    = ENV_ATTACK;
                            n_retrig = 1'b1;
                        end
                    end
                    n_key     = r_key;
                    n_vel     = r_vel;
                    n_started = (c_st == ST_OFF);
                    n_st      = ST_ON;
                end
                OP_NOTE_OFF: begin
                    n_rel = r_vel;
                    if (w_mono && r_hv[0]) begin
                        if (!r_prev_valid || (r_hk[0] != r_prev_key)) begin
                            n_key = r_hk[0];
                            n_tgt = r_hk[0];
                            if (w_g inside {GLIDE_INITIAL, GLIDE_OFF}) begin
                                n_gs = r_hk[0];
                            end
                            if ((r_mono == MONO_BOTH) && (c_st != ST_REL)) begin
                                n_env    = ENV_ATTACK;
                                n_retrig = 1'b1;
                            end
                        end
                    end else if (r_sus) begin
                        if (c_st != ST_REL) begin
                            n_st = ST_SUS;
                        end
                    end else begin
                        n_env = ENV_RELEASE;
                        n_st  = ST_REL;
                    end
                end
                OP_FORCE_REL: begin
                    if (c_st == ST_ON) begin
                        n_rel = REL_VEL_FORCED;
                    end
                    n_env = ENV_RELEASE;
                    n_st  = ST_REL;
                end
                default: begin
                end
            endcase
        end

        n_res.voice_number       = r_vnum;
        n_res.voice_status       = w_in_range ? n_st  : '0;
        n_res.voice_key_now      = w_in_range ? n_key : '0;
        n_res.target_key         = w_in_range ? n_tgt : '0;
        n_res.glide_from_key     = w_in_range ? n_gs  : '0;
        n_res.note_velocity      = w_in_range ? n_vel : '0;
        n_res.release_velocity   = w_in_range ? n_rel : '0;
        n_res.envelope_phase     = w_in_range ? n_env : '0;
        n_res.envelope_retrigger = n_retrig;
        n_res.voice_started      = n_started;
        n_res.top_held_key       = r_hv[0] ? r_hk[0] : '0;
        n_res.top_held_valid     = r_hv[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_mono       <= MONO_POLY;
            r_glide      <= GLIDE_OFF;
            r_last_onset <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < HELD_DEPTH; i++) begin
                r_hv[i] <= 1'b0;
                r_hk[i] <= '0;
            end
            for (int i = 0; i < VOICES; i++) begin
                r_vs[i] <= ST_OFF;
                r_vk[i] <= '0;
                r_vv[i] <= '0;
                r_vr[i] <= '0;
                r_vt[i] <= '0;
                r_vg[i] <= '0;
                r_ve[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_MONO:  r_mono  <= i_cfg.data[MONO_W-1:0];
                    CFG_GLIDE: r_glide <= i_cfg.data[GLIDE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_UPDATE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_voice.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_op         <= i_note.op;
                        r_vnum       <= i_note.voice_index;
                        r_key        <= i_note.key;
                        r_vel        <= i_note.velocity;
                        r_sus        <= i_note.sustain_down;
                        r_prev_valid <= r_hv[0];
                        r_prev_key   <= r_hk[0];
                        if ((int'(i_note.voice_index) < VOICES) &&
                            (i_note.op inside {OP_NOTE_ON, OP_NOTE_OFF})) begin
                            r_idx   <= (i_note.op == OP_NOTE_ON) ? '0 : H_LAST;
                            r_state <= S_SEARCH;
                        end else begin
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_SEARCH: begin
                    if (r_op == OP_NOTE_ON) begin
                        if (w_hit) begin
                            r_state <= S_SHIFT;
                        end else if (r_idx == H_PEN) begin
                            r_idx   <= H_LAST;
                            r_state <= S_SHIFT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        if (w_hit) begin
                            r_state <= S_SHIFT;
                        end else if (r_idx == '0) begin
                            r_state <= S_UPDATE;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                S_SHIFT: begin
                    for (int i = 0; i < HELD_DEPTH; i++) begin
                        r_hv[i] <= n_hv[i];
                        r_hk[i] <= n_hk[i];
                    end
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (w_out_free) begin
                        r_res <= n_res;
                        if (w_in_range) begin
                            r_vs[w_vsel] <= n_st;
                            r_vk[w_vsel] <= n_key;
                            r_vt[w_vsel] <= n_tgt;
                            r_vg[w_vsel] <= n_gs;
                            r_vv[w_vsel] <= n_vel;
                            r_vr[w_vsel] <= n_rel;
                            r_ve[w_vsel] <= n_env;
                            if (r_op == OP_NOTE_ON) begin
                                r_last_onset <= r_key;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_voice.valid              = r_out_valid;
    assign o_voice.voice_number       = r_res.voice_number;
    assign o_voice.voice_status       = r_res.voice_status;
    assign o_voice.voice_key_now      = r_res.voice_key_now;
    assign o_voice.target_key         = r_res.target_key;
    assign o_voice.glide_from_key     = r_res.glide_from_key;
    assign o_voice.note_velocity      = r_res.note_velocity;
    assign o_voice.release_velocity   = r_res.release_velocity;
    assign o_voice.envelope_phase     = r_res.envelope_phase;
    assign o_voice.envelope_retrigger = r_res.envelope_retrigger;
    assign o_voice.voice_started      = r_res.voice_started;
    assign o_voice.top_held_key       = r_res.top_held_key;
    assign o_voice.top_held_valid     = r_res.top_held_valid;

endmodule
`default_nettype wire

[hw/rtl/svnc_checker.sv]
`default_nettype none
module svnc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [svnc_pkg::VIDX_W-1:0] voice_number,
    input logic [svnc_pkg::STAT_W-1:0] voice_status,
    input logic [svnc_pkg::ENV_W-1:0]  envelope_phase,
    input logic                       envelope_retrigger,
    input logic                       voice_started,
    input logic [svnc_pkg::KEY_W-1:0]  top_held_key,
    input logic                       top_held_valid
);
    import svnc_pkg::*;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("note channel ready right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(voice_number) &&
                                       $stable(voice_status) && $stable(top_held_key)))
        else $error("stalled result changed");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !top_held_valid) |-> (top_held_key == '0))
        else $error("empty stack reports a key");

    a_start_attack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && voice_started) |-> (envelope_retrigger && (voice_status == ST_ON) &&
                                          (envelope_phase == ENV_ATTACK)))
        else $error("started voice not in attack");

endmodule

bind synth_voice_note_controller_unit svnc_checker u_svnc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .in_valid           (i_note.valid),
    .in_ready           (i_note.ready),
    .out_valid          (o_voice.valid),
    .out_ready          (o_voice.ready),
    .voice_number       (o_voice.voice_number),
    .voice_status       (o_voice.voice_status),
    .envelope_phase     (o_voice.envelope_phase),
    .envelope_retrigger (o_voice.envelope_retrigger),
    .voice_started      (o_voice.voice_started),
    .top_held_key       (o_voice.top_held_key),
    .top_held_valid     (o_voice.top_held_valid)
);
`default_nettype wire
